@@ rtl/svn_pkg.sv @@
// types and constants shared by the smooth vertex normals block
package svn_pkg;

  localparam int POS_BITS = 24;
  localparam int NRM_BITS = 16;
  localparam int IDX_BITS = 12;
  localparam int ACC_BITS = 64;
  localparam int MAG_BITS = 24;
  localparam int LEN_BITS = 32;
  localparam logic [NRM_BITS-1:0] NRM_ONE = NRM_BITS'(1) << (NRM_BITS - 2);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TRI,
    OP_FINISH,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_FULL,
    ST_RANGE,
    ST_EMPTY,
    ST_PHASE
  } status_t;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_LOADING,
    PH_TRIANGLES,
    PH_FINISHED
  } phase_t;

  typedef enum logic [1:0] {
    SRC_FACES,
    SRC_VERTEX,
    SRC_UP
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TRI_RD,
    S_TRI_CAP,
    S_EDGE,
    S_CROSS,
    S_ACC_RD,
    S_ACC_WR,
    S_FIN_RD,
    S_FIN_SEL,
    S_FIN_NORM,
    S_RD_WAIT,
    S_RESP
  } state_t;

  typedef enum logic [3:0] {
    N_IDLE,
    N_MAX,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DLOAD,
    N_DIV,
    N_DONE
  } nrm_state_t;

  typedef struct packed {
    op_t                         operation;
    logic signed [POS_BITS-1:0]  pos_x;
    logic signed [POS_BITS-1:0]  pos_y;
    logic signed [POS_BITS-1:0]  pos_z;
    logic [IDX_BITS-1:0]         corner_a;
    logic [IDX_BITS-1:0]         corner_b;
    logic [IDX_BITS-1:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    status_t                     status;
    logic signed [NRM_BITS-1:0]  normal_x;
    logic signed [NRM_BITS-1:0]  normal_y;
    logic signed [NRM_BITS-1:0]  normal_z;
    src_t                        normal_source;
  } out_item_t;

  typedef struct packed {
    logic                        start;
    logic [2:0][ACC_BITS-1:0]    vec;
  } nrm_req_t;

  typedef struct packed {
    logic                        done;
    logic [2:0][NRM_BITS-1:0]    n;
  } nrm_rsp_t;

endpackage

@@ rtl/svn_norm.sv @@
// iterative normalizer: shift search, sum of squares, square root, divide
module svn_norm (
  input  logic              clk,
  input  logic              rst_n,
  input  svn_pkg::nrm_req_t req,
  output svn_pkg::nrm_rsp_t rsp
);

  localparam int AB  = svn_pkg::ACC_BITS;
  localparam int MB  = svn_pkg::MAG_BITS;
  localparam int NB  = svn_pkg::NRM_BITS;
  localparam int LW  = svn_pkg::LEN_BITS;
  localparam int DW  = MB + NB + 6;
  localparam int RW  = LW + 2;
  localparam int QCW = $clog2(DW + 1);
  localparam int QW  = 2 * MB + 2;

  svn_pkg::nrm_state_t st_r, st_nxt;

  logic [2:0]          sgn_r, sgn_nxt;
  logic [2:0][AB-1:0]  mag_r, mag_nxt;
  logic [AB-1:0]       m_r, m_nxt;
  logic [1:0]          j_r, j_nxt;
  logic [2*MB-1:0]     sq_r;
  logic [MB-1:0]       sq_op;
  logic [QW-1:0]       q_r, q_nxt;
  logic [63:0]         v_r, v_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic [63:0]         trial;
  logic [DW-1:0]       dd_r, dd_nxt;
  logic [RW-1:0]       rem_r, rem_nxt, rem_sh;
  logic [QCW-1:0]      bc_r, bc_nxt;
  logic [2:0][NB-1:0]  n_r, n_nxt;
  logic [LW:0]         dv;
  logic                qbit;
  logic [DW-1:0]       quo;
  logic [NB-1:0]       r_clamp;

  assign trial  = rt_r + bit_r;
  assign dv     = {rt_r[LW-1:0], 1'b0};
  assign rem_sh = {rem_r[RW-2:0], dd_r[DW-1]};
  assign qbit   = rem_sh >= RW'(dv);
  assign quo    = {dd_r[DW-2:0], qbit};
  assign r_clamp = (quo > DW'(svn_pkg::NRM_ONE)) ? svn_pkg::NRM_ONE : quo[NB-1:0];
  assign sq_op  = mag_r[j_r][MB-1:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      svn_pkg::N_IDLE:  if (req.start) st_nxt = svn_pkg::N_MAX;
      svn_pkg::N_MAX:   st_nxt = svn_pkg::N_SHIFT;
      svn_pkg::N_SHIFT: if (m_r[AB-1:MB] == '0) st_nxt = svn_pkg::N_SQ;
      svn_pkg::N_SQ:    if (j_r == 2'd3) st_nxt = svn_pkg::N_SQRT;
      svn_pkg::N_SQRT:  if (bit_r[0]) st_nxt = svn_pkg::N_DLOAD;
      svn_pkg::N_DLOAD: st_nxt = svn_pkg::N_DIV;
      svn_pkg::N_DIV: begin
        if (bc_r == QCW'(DW - 1)) begin
          st_nxt = (j_r == 2'd2) ? svn_pkg::N_DONE : svn_pkg::N_DLOAD;
        end
      end
      svn_pkg::N_DONE:  st_nxt = svn_pkg::N_IDLE;
      default:          st_nxt = svn_pkg::N_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    sgn_nxt = sgn_r;
    mag_nxt = mag_r;
    m_nxt   = m_r;
    j_nxt   = j_r;
    q_nxt   = q_r;
    v_nxt   = v_r;
    rt_nxt  = rt_r;
    bit_nxt = bit_r;
    dd_nxt  = dd_r;
    rem_nxt = rem_r;
    bc_nxt  = bc_r;
    n_nxt   = n_r;
    case (st_r)
      svn_pkg::N_IDLE: begin
        for (int i = 0; i < 3; i++) begin
          sgn_nxt[i] = req.vec[i][AB-1];
          mag_nxt[i] = req.vec[i][AB-1] ? (~req.vec[i] + AB'(1)) : req.vec[i];
        end
      end
      svn_pkg::N_MAX: begin
        m_nxt = mag_r[0];
        if (mag_r[1] > m_nxt) m_nxt = mag_r[1];
        if (mag_r[2] > m_nxt) m_nxt = mag_r[2];
      end
      svn_pkg::N_SHIFT: begin
        // coarse steps of eight while far above range, then single bits
        if (m_r[AB-1:MB+8] != '0) begin
          m_nxt = m_r >> 8;
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 8;
        end else if (m_r[AB-1:MB] != '0) begin
          m_nxt = m_r >> 1;
          for (int i = 0; i < 3; i++) mag_nxt[i] = mag_r[i] >> 1;
        end else begin
          j_nxt = 2'd0;
        end
      end
      svn_pkg::N_SQ: begin
        j_nxt = j_r + 2'd1;
        if (j_r == 2'd0) q_nxt = '0;
        else q_nxt = q_r + QW'(sq_r);
        if (j_r == 2'd3) begin
          v_nxt   = 64'(q_r + QW'(sq_r)) << 12;
          rt_nxt  = '0;
          bit_nxt = 64'(1) << 62;
          j_nxt   = 2'd0;
        end
      end
      svn_pkg::N_SQRT: begin
        if (v_r >= trial) begin
          v_nxt  = v_r - trial;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      svn_pkg::N_DLOAD: begin
        dd_nxt  = (DW'(mag_r[j_r][MB-1:0]) << (NB + 5)) + DW'(rt_r[LW-1:0]);
        rem_nxt = '0;
        bc_nxt  = '0;
      end
      svn_pkg::N_DIV: begin
        rem_nxt = qbit ? (rem_sh - RW'(dv)) : rem_sh;
        dd_nxt  = quo;
        bc_nxt  = bc_r + QCW'(1);
        if (bc_r == QCW'(DW - 1)) begin
          n_nxt[j_r] = sgn_r[j_r] ? (~r_clamp + NB'(1)) : r_clamp;
          j_nxt      = j_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= svn_pkg::N_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sgn_r <= sgn_nxt;
    mag_r <= mag_nxt;
    m_r   <= m_nxt;
    j_r   <= j_nxt;
    sq_r  <= sq_op * sq_op;
    q_r   <= q_nxt;
    v_r   <= v_nxt;
    rt_r  <= rt_nxt;
    bit_r <= bit_nxt;
    dd_r  <= dd_nxt;
    rem_r <= rem_nxt;
    bc_r  <= bc_nxt;
    n_r   <= n_nxt;
  end

  assign rsp.done = (st_r == svn_pkg::N_DONE);
  assign rsp.n    = n_r;

endmodule

@@ rtl/smooth_vertex_normals.sv @@
// top level of the smooth vertex normals block
// Builds area-weighted vertex normals one request at a time: load vertex, add triangle,
// finish and read normal. A request is taken only while the sequencer is idle; its
// result goes to an output register, so the next request can be taken while that
// result still waits. A triangle takes three position reads, six products through one
// shared multiplier, then a read-modify-write of the accumulator memory for each
// corner; no accumulator is written when the cross product is zero. Finish walks
// every loaded vertex through the shared normalizer (shift search, three squares, a
// 32-step square root and three bit-serial divides of 46 steps each); a vertex that
// falls back to the default up skips it. This normalizer sets the finish time.
// Accumulators are 64-bit saturating, positions signed Q8.16, normals signed Q1.14.
module smooth_vertex_normals #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  svn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output svn_pkg::out_item_t out_data
);

  localparam int PB = svn_pkg::POS_BITS;
  localparam int AB = svn_pkg::ACC_BITS;
  localparam int NB = svn_pkg::NRM_BITS;
  localparam int IB = svn_pkg::IDX_BITS;
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int KW = (CW > IB) ? CW : IB;
  localparam int EW = PB + 1;
  localparam int PW = 2 * EW;
  localparam int XW = PW + 1;
  localparam int NW = 3 * NB + 2;

  // memories
  logic [3*PB-1:0] pos_mem [MAX_VERTICES];
  logic [3*AB-1:0] acc_mem [MAX_VERTICES];
  logic [NW-1:0]   nrm_mem [MAX_VERTICES];

  logic            pos_we, acc_we, nrm_we;
  logic [AW-1:0]   pos_waddr, acc_waddr, nrm_waddr;
  logic [AW-1:0]   pos_raddr, acc_raddr, nrm_raddr;
  logic [3*PB-1:0] pos_wdata, pos_rd_r;
  logic [3*AB-1:0] acc_wdata, acc_rd_r;
  logic [NW-1:0]   nrm_wdata, nrm_rd_r;

  // sequencer and mesh state
  svn_pkg::state_t    state_r, state_nxt;
  svn_pkg::phase_t    phase_r, phase_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, cnt_eff;
  logic               err_r, err_nxt;
  svn_pkg::in_item_t  item_r, item_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [2:0]         t_r, t_nxt;
  logic [CW-1:0]      fi_r, fi_nxt;
  svn_pkg::src_t      src_r, src_nxt;
  svn_pkg::out_item_t res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  svn_pkg::out_item_t out_data_r, out_data_nxt;

  // triangle datapath
  logic [3*PB-1:0]          p_r [3];
  logic [3*PB-1:0]          p_nxt [3];
  logic signed [EW-1:0]     e0_r [3];
  logic signed [EW-1:0]     e1_r [3];
  logic signed [EW-1:0]     e0_nxt [3];
  logic signed [EW-1:0]     e1_nxt [3];
  logic signed [EW-1:0]     mul_a, mul_b;
  logic signed [PW-1:0]     prod_r;
  logic [2:0][XW-1:0]       cross_r, cross_nxt;
  logic signed [AB:0]       sum_w [3];
  logic [2:0][AB-1:0]       sat_w;
  logic [2:0]               lane_t;

  svn_pkg::nrm_req_t nrm_req;
  svn_pkg::nrm_rsp_t nrm_rsp;

  // decode helpers
  logic          in_acc, resp_go, fin_last;
  logic          bad_a, bad_b, bad_c, bad_any, cross_zero;
  logic          acc_zero, pos_zero, old_mesh;
  logic [IB-1:0] corner_k;
  logic [AW-1:0] corner_addr;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != svn_pkg::S_IDLE);
  assign resp_go    = !out_valid_r || !out_stall;
  assign old_mesh   = (phase_r == svn_pkg::PH_TRIANGLES) || (phase_r == svn_pkg::PH_FINISHED);
  assign cnt_eff    = old_mesh ? '0 : cnt_r;
  assign bad_a      = KW'(item_r.corner_a) >= KW'(cnt_r);
  assign bad_b      = KW'(item_r.corner_b) >= KW'(cnt_r);
  assign bad_c      = KW'(item_r.corner_c) >= KW'(cnt_r);
  assign bad_any    = bad_a || bad_b || bad_c;
  assign cross_zero = (cross_r == '0);
  assign acc_zero   = (acc_rd_r == '0);
  assign pos_zero   = (pos_rd_r == '0);
  assign fin_last   = (CW'(fi_r + CW'(1)) == cnt_r);
  assign corner_k   = (k_r == 2'd0) ? item_r.corner_a :
                      (k_r == 2'd1) ? item_r.corner_b : item_r.corner_c;
  assign corner_addr = AW'(corner_k);

  // product pairs of the cross product, two per lane, second one subtracted
  always_comb begin
    case (t_r)
      3'd0:    begin mul_a = e0_r[1]; mul_b = e1_r[2]; end
      3'd1:    begin mul_a = e0_r[2]; mul_b = e1_r[1]; end
      3'd2:    begin mul_a = e0_r[2]; mul_b = e1_r[0]; end
      3'd3:    begin mul_a = e0_r[0]; mul_b = e1_r[2]; end
      3'd4:    begin mul_a = e0_r[0]; mul_b = e1_r[1]; end
      3'd5:    begin mul_a = e0_r[1]; mul_b = e1_r[0]; end
      default: begin mul_a = e0_r[0]; mul_b = e1_r[0]; end
    endcase
  end

  assign lane_t = 3'(t_r - 3'd1) >> 1;

  // saturating accumulator lanes
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sum_w[l] = (AB+1)'($signed(acc_rd_r[(2-l)*AB +: AB])) + (AB+1)'($signed(cross_r[l]));
      if (sum_w[l][AB] != sum_w[l][AB-1]) begin
        sat_w[l] = sum_w[l][AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
      end else begin
        sat_w[l] = sum_w[l][AB-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      svn_pkg::S_IDLE: if (in_acc) state_nxt = svn_pkg::S_DECODE;
      svn_pkg::S_DECODE: begin
        state_nxt = svn_pkg::S_RESP;
        case (item_r.operation)
          svn_pkg::OP_TRI: begin
            if (phase_r != svn_pkg::PH_EMPTY && phase_r != svn_pkg::PH_FINISHED && !bad_any) begin
              state_nxt = svn_pkg::S_TRI_RD;
            end
          end
          svn_pkg::OP_FINISH: begin
            if (phase_r != svn_pkg::PH_EMPTY && !err_r) state_nxt = svn_pkg::S_FIN_RD;
          end
          svn_pkg::OP_READ: begin
            if (phase_r == svn_pkg::PH_FINISHED && !bad_a) state_nxt = svn_pkg::S_RD_WAIT;
          end
          default: ;
        endcase
      end
      svn_pkg::S_TRI_RD:  state_nxt = svn_pkg::S_TRI_CAP;
      svn_pkg::S_TRI_CAP: state_nxt = (k_r == 2'd2) ? svn_pkg::S_EDGE : svn_pkg::S_TRI_RD;
      svn_pkg::S_EDGE:    state_nxt = svn_pkg::S_CROSS;
      svn_pkg::S_CROSS:   if (t_r == 3'd6) state_nxt = svn_pkg::S_ACC_RD;
      svn_pkg::S_ACC_RD:  state_nxt = cross_zero ? svn_pkg::S_RESP : svn_pkg::S_ACC_WR;
      svn_pkg::S_ACC_WR:  state_nxt = (k_r == 2'd2) ? svn_pkg::S_RESP : svn_pkg::S_ACC_RD;
      svn_pkg::S_FIN_RD:  state_nxt = svn_pkg::S_FIN_SEL;
      svn_pkg::S_FIN_SEL: begin
        if (!acc_zero || !pos_zero) state_nxt = svn_pkg::S_FIN_NORM;
        else state_nxt = fin_last ? svn_pkg::S_RESP : svn_pkg::S_FIN_RD;
      end
      svn_pkg::S_FIN_NORM: begin
        if (nrm_rsp.done) state_nxt = fin_last ? svn_pkg::S_RESP : svn_pkg::S_FIN_RD;
      end
      svn_pkg::S_RD_WAIT: state_nxt = svn_pkg::S_RESP;
      svn_pkg::S_RESP:    if (resp_go) state_nxt = svn_pkg::S_IDLE;
      default:            state_nxt = svn_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    item_nxt      = item_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    fi_nxt        = fi_r;
    src_nxt       = src_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    cross_nxt     = cross_r;
    for (int i = 0; i < 3; i++) begin
      p_nxt[i]  = p_r[i];
      e0_nxt[i] = e0_r[i];
      e1_nxt[i] = e1_r[i];
    end
    pos_we    = 1'b0;
    acc_we    = 1'b0;
    nrm_we    = 1'b0;
    pos_waddr = AW'(cnt_eff);
    acc_waddr = AW'(cnt_eff);
    nrm_waddr = AW'(fi_r);
    pos_raddr = AW'(fi_r);
    acc_raddr = AW'(fi_r);
    nrm_raddr = AW'(item_r.corner_a);
    pos_wdata = {item_r.pos_x, item_r.pos_y, item_r.pos_z};
    acc_wdata = '0;
    nrm_wdata = {src_r, nrm_rsp.n[0], nrm_rsp.n[1], nrm_rsp.n[2]};
    nrm_req.start = 1'b0;
    // lane 0 of the normalizer is x, held in the top bits of the accumulator word
    for (int l = 0; l < 3; l++) nrm_req.vec[l] = acc_rd_r[(2-l)*AB +: AB];

    case (state_r)
      svn_pkg::S_IDLE: if (in_acc) item_nxt = in_data;
      svn_pkg::S_DECODE: begin
        res_nxt        = '0;
        res_nxt.status = svn_pkg::ST_OK;
        k_nxt          = 2'd0;
        fi_nxt         = '0;
        case (item_r.operation)
          svn_pkg::OP_LOAD: begin
            // a load after triangles or finish starts a new mesh
            if (old_mesh) begin
              cnt_nxt   = '0;
              err_nxt   = 1'b0;
              phase_nxt = svn_pkg::PH_EMPTY;
            end
            if (cnt_eff >= CW'(MAX_VERTICES)) begin
              res_nxt.status = svn_pkg::ST_FULL;
            end else begin
              pos_we    = 1'b1;
              acc_we    = 1'b1;
              cnt_nxt   = CW'(cnt_eff + CW'(1));
              phase_nxt = svn_pkg::PH_LOADING;
            end
          end
          svn_pkg::OP_TRI: begin
            if (phase_r == svn_pkg::PH_EMPTY) begin
              res_nxt.status = svn_pkg::ST_EMPTY;
            end else if (phase_r == svn_pkg::PH_FINISHED) begin
              res_nxt.status = svn_pkg::ST_PHASE;
            end else begin
              phase_nxt = svn_pkg::PH_TRIANGLES;
              if (bad_any) begin
                res_nxt.status = svn_pkg::ST_RANGE;
                err_nxt        = 1'b1;
              end
            end
          end
          svn_pkg::OP_FINISH: begin
            if (phase_r == svn_pkg::PH_EMPTY) res_nxt.status = svn_pkg::ST_EMPTY;
            else if (err_r) res_nxt.status = svn_pkg::ST_RANGE;
          end
          svn_pkg::OP_READ: begin
            if (phase_r == svn_pkg::PH_EMPTY) res_nxt.status = svn_pkg::ST_EMPTY;
            else if (phase_r != svn_pkg::PH_FINISHED) res_nxt.status = svn_pkg::ST_PHASE;
            else if (bad_a) res_nxt.status = svn_pkg::ST_RANGE;
          end
          default: ;
        endcase
      end
      svn_pkg::S_TRI_RD: pos_raddr = corner_addr;
      svn_pkg::S_TRI_CAP: begin
        p_nxt[k_r] = pos_rd_r;
        k_nxt      = k_r + 2'd1;
      end
      svn_pkg::S_EDGE: begin
        for (int l = 0; l < 3; l++) begin
          e0_nxt[l] = EW'($signed(p_r[1][(2-l)*PB +: PB])) - EW'($signed(p_r[0][(2-l)*PB +: PB]));
          e1_nxt[l] = EW'($signed(p_r[2][(2-l)*PB +: PB])) - EW'($signed(p_r[0][(2-l)*PB +: PB]));
        end
        t_nxt = 3'd0;
      end
      svn_pkg::S_CROSS: begin
        t_nxt = t_r + 3'd1;
        // product of the previous step lands in its lane
        if (t_r != 3'd0) begin
          if (t_r[0]) cross_nxt[lane_t[1:0]] = XW'(prod_r);
          else cross_nxt[lane_t[1:0]] = cross_r[lane_t[1:0]] - XW'(prod_r);
        end
        k_nxt = 2'd0;
      end
      svn_pkg::S_ACC_RD: acc_raddr = corner_addr;
      svn_pkg::S_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = corner_addr;
        acc_wdata = {sat_w[0], sat_w[1], sat_w[2]};
        k_nxt     = k_r + 2'd1;
      end
      svn_pkg::S_FIN_RD: begin
        pos_raddr = AW'(fi_r);
        acc_raddr = AW'(fi_r);
      end
      svn_pkg::S_FIN_SEL: begin
        if (!acc_zero) begin
          nrm_req.start = 1'b1;
          src_nxt       = svn_pkg::SRC_FACES;
        end else if (!pos_zero) begin
          // fall back to the vertex direction
          nrm_req.start = 1'b1;
          for (int l = 0; l < 3; l++) begin
            nrm_req.vec[l] = AB'($signed(pos_rd_r[(2-l)*PB +: PB]));
          end
          src_nxt = svn_pkg::SRC_VERTEX;
        end else begin
          // default up
          nrm_we    = 1'b1;
          nrm_wdata = {svn_pkg::SRC_UP, NB'(0), NB'(0), svn_pkg::NRM_ONE};
          fi_nxt    = CW'(fi_r + CW'(1));
          if (fin_last) phase_nxt = svn_pkg::PH_FINISHED;
        end
      end
      svn_pkg::S_FIN_NORM: begin
        if (nrm_rsp.done) begin
          nrm_we = 1'b1;
          fi_nxt = CW'(fi_r + CW'(1));
          if (fin_last) phase_nxt = svn_pkg::PH_FINISHED;
        end
      end
      svn_pkg::S_RD_WAIT: begin
        res_nxt.normal_source = svn_pkg::src_t'(nrm_rd_r[NW-1 -: 2]);
        res_nxt.normal_x      = nrm_rd_r[3*NB-1 -: NB];
        res_nxt.normal_y      = nrm_rd_r[2*NB-1 -: NB];
        res_nxt.normal_z      = nrm_rd_r[NB-1:0];
      end
      svn_pkg::S_RESP: begin
        if (resp_go) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd_r <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[nrm_waddr] <= nrm_wdata;
    nrm_rd_r <= nrm_mem[nrm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svn_pkg::S_IDLE;
      phase_r     <= svn_pkg::PH_EMPTY;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    k_r        <= k_nxt;
    t_r        <= t_nxt;
    fi_r       <= fi_nxt;
    src_r      <= src_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    cross_r    <= cross_nxt;
    prod_r     <= mul_a * mul_b;
    for (int i = 0; i < 3; i++) begin
      p_r[i]  <= p_nxt[i];
      e0_r[i] <= e0_nxt[i];
      e1_r[i] <= e1_nxt[i];
    end
  end

  svn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nrm_req),
    .rsp   (nrm_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // vertex count stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  // any mesh phase other than empty holds at least one vertex
  a_mesh_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != svn_pkg::PH_EMPTY |-> cnt_r != '0)
    else $error("mesh phase with no vertices");

  // normalizer completes only while the finish walk waits on it
  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    nrm_rsp.done |-> state_r == svn_pkg::S_FIN_NORM)
    else $error("normalizer done outside finish walk");

  // a request is taken only once the previous result has been handed to the output
  a_resp_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == svn_pkg::S_RESP && resp_go |=> out_valid_r && state_r == svn_pkg::S_IDLE)
    else $error("result not handed to output register");
`endif

endmodule

@@ tb/smooth_vertex_normals_tb.sv @@
// self-checking testbench for the smooth vertex normals block
`timescale 1ns / 100ps

// mirrors the mesh state and queues the expected result of every request
class normal_scoreboard;
  localparam int DEPTH = 4096;
  localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;

  longint vtx_x[DEPTH];
  longint vtx_y[DEPTH];
  longint vtx_z[DEPTH];
  longint sum_x[DEPTH];
  longint sum_y[DEPTH];
  longint sum_z[DEPTH];
  svn_pkg::out_item_t normal_mem[DEPTH];
  int unsigned vertex_total;
  svn_pkg::phase_t mesh_phase;
  bit bad_corner_seen;
  svn_pkg::out_item_t pending[$];
  int errors;

  function new();
    vertex_total = 0;
    mesh_phase = svn_pkg::PH_EMPTY;
    bad_corner_seen = 0;
    errors = 0;
  endfunction

  function longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) return SUM_MAX;
    if (b < 0 && s > a) return SUM_MIN;
    return s;
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // exact integer normalization to Q1.14, round half up on the magnitude
  function void unit_vector(input longint c0, c1, c2,
                            output logic [15:0] n0, n1, n2);
    longint c[3];
    logic [63:0] mag[3];
    logic [63:0] m, q, len, num, r;
    int s;
    c[0] = c0; c[1] = c1; c[2] = c2;
    for (int i = 0; i < 3; i++) mag[i] = (c[i] < 0) ? -c[i] : c[i];
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    s = 0;
    while ((m >> s) >= (64'd1 << 24)) s++;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> s;
      q = q + mag[i] * mag[i];
    end
    len = int_sqrt(q << 12);
    for (int i = 0; i < 3; i++) begin
      num = mag[i] << 20;
      r = (2 * num + len) / (2 * len);
      if (r > svn_pkg::NRM_ONE) r = svn_pkg::NRM_ONE;
      if (c[i] < 0) r = -r;
      if (i == 0) n0 = r[15:0];
      else if (i == 1) n1 = r[15:0];
      else n2 = r[15:0];
    end
  endfunction

  function void finish_mesh();
    svn_pkg::out_item_t e;
    for (int unsigned i = 0; i < vertex_total; i++) begin
      e = '0;
      e.status = svn_pkg::ST_OK;
      if (sum_x[i] != 0 || sum_y[i] != 0 || sum_z[i] != 0) begin
        unit_vector(sum_x[i], sum_y[i], sum_z[i], e.normal_x, e.normal_y, e.normal_z);
        e.normal_source = svn_pkg::SRC_FACES;
      end else if (vtx_x[i] != 0 || vtx_y[i] != 0 || vtx_z[i] != 0) begin
        unit_vector(vtx_x[i], vtx_y[i], vtx_z[i], e.normal_x, e.normal_y, e.normal_z);
        e.normal_source = svn_pkg::SRC_VERTEX;
      end else begin
        e.normal_z = svn_pkg::NRM_ONE;
        e.normal_source = svn_pkg::SRC_UP;
      end
      normal_mem[i] = e;
    end
  endfunction

  function void note_request(svn_pkg::in_item_t r);
    svn_pkg::out_item_t e;
    int unsigned k[3];
    longint e0x, e0y, e0z, e1x, e1y, e1z, cx, cy, cz;
    e = '0;
    e.status = svn_pkg::ST_OK;
    e.normal_source = svn_pkg::SRC_FACES;
    k[0] = 32'(r.corner_a); k[1] = 32'(r.corner_b); k[2] = 32'(r.corner_c);
    case (r.operation)
      svn_pkg::OP_LOAD: begin
        if (mesh_phase == svn_pkg::PH_TRIANGLES || mesh_phase == svn_pkg::PH_FINISHED) begin
          vertex_total = 0;
          bad_corner_seen = 0;
          mesh_phase = svn_pkg::PH_EMPTY;
        end
        if (vertex_total >= DEPTH) begin
          e.status = svn_pkg::ST_FULL;
        end else begin
          vtx_x[vertex_total] = longint'(r.pos_x);
          vtx_y[vertex_total] = longint'(r.pos_y);
          vtx_z[vertex_total] = longint'(r.pos_z);
          sum_x[vertex_total] = 0;
          sum_y[vertex_total] = 0;
          sum_z[vertex_total] = 0;
          vertex_total++;
          mesh_phase = svn_pkg::PH_LOADING;
        end
      end
      svn_pkg::OP_TRI: begin
        if (mesh_phase == svn_pkg::PH_EMPTY) begin
          e.status = svn_pkg::ST_EMPTY;
        end else if (mesh_phase == svn_pkg::PH_FINISHED) begin
          e.status = svn_pkg::ST_PHASE;
        end else if (k[0] >= vertex_total || k[1] >= vertex_total || k[2] >= vertex_total) begin
          e.status = svn_pkg::ST_RANGE;
          bad_corner_seen = 1;
          mesh_phase = svn_pkg::PH_TRIANGLES;
        end else begin
          e0x = vtx_x[k[1]] - vtx_x[k[0]];
          e0y = vtx_y[k[1]] - vtx_y[k[0]];
          e0z = vtx_z[k[1]] - vtx_z[k[0]];
          e1x = vtx_x[k[2]] - vtx_x[k[0]];
          e1y = vtx_y[k[2]] - vtx_y[k[0]];
          e1z = vtx_z[k[2]] - vtx_z[k[0]];
          cx = e0y * e1z - e0z * e1y;
          cy = e0z * e1x - e0x * e1z;
          cz = e0x * e1y - e0y * e1x;
          mesh_phase = svn_pkg::PH_TRIANGLES;
          // degenerate faces leave the sums alone
          if (cx != 0 || cy != 0 || cz != 0) begin
            for (int j = 0; j < 3; j++) begin
              sum_x[k[j]] = sat_sum(sum_x[k[j]], cx);
              sum_y[k[j]] = sat_sum(sum_y[k[j]], cy);
              sum_z[k[j]] = sat_sum(sum_z[k[j]], cz);
            end
          end
        end
      end
      svn_pkg::OP_FINISH: begin
        if (mesh_phase == svn_pkg::PH_EMPTY) begin
          e.status = svn_pkg::ST_EMPTY;
        end else if (bad_corner_seen) begin
          e.status = svn_pkg::ST_RANGE;
        end else begin
          finish_mesh();
          mesh_phase = svn_pkg::PH_FINISHED;
        end
      end
      default: begin
        if (mesh_phase == svn_pkg::PH_EMPTY) begin
          e.status = svn_pkg::ST_EMPTY;
        end else if (mesh_phase != svn_pkg::PH_FINISHED) begin
          e.status = svn_pkg::ST_PHASE;
        end else if (k[0] >= vertex_total) begin
          e.status = svn_pkg::ST_RANGE;
        end else begin
          e = normal_mem[k[0]];
        end
      end
    endcase
    pending.push_back(e);
  endfunction

  function void check_result(svn_pkg::out_item_t got);
    svn_pkg::out_item_t e;
    if (pending.size() == 0) begin
      $error("unexpected result: status %0d", got.status);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, got.status);
      errors++;
    end
    if (got.normal_x !== e.normal_x) begin
      $error("normal_x: expected %0d, actual %0d", e.normal_x, got.normal_x);
      errors++;
    end
    if (got.normal_y !== e.normal_y) begin
      $error("normal_y: expected %0d, actual %0d", e.normal_y, got.normal_y);
      errors++;
    end
    if (got.normal_z !== e.normal_z) begin
      $error("normal_z: expected %0d, actual %0d", e.normal_z, got.normal_z);
      errors++;
    end
    if (got.normal_source !== e.normal_source) begin
      $error("normal_source: expected %0d, actual %0d", e.normal_source,
             got.normal_source);
      errors++;
    end
  endfunction
endclass

module smooth_vertex_normals_tb;

  localparam int IDLE_LIMIT = 40000;  // longest finish plus the long hold, with margin
  localparam int HOLD_CYCLES = 400;
  localparam int TOTAL_ITEMS = 1200;
  localparam logic signed [23:0] POS_MAX = 24'sh7fffff;
  localparam logic signed [23:0] POS_MIN = 24'sh800000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  svn_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  svn_pkg::out_item_t out_data;

  normal_scoreboard sb;
  int burst_left;
  bit hold_req;      // asks the receiver for its one long hold-off
  int items_sent;

  smooth_vertex_normals i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // build one request
  function automatic svn_pkg::in_item_t req(svn_pkg::op_t op, logic [23:0] x,
                                            logic [23:0] y, logic [23:0] z,
                                            logic [11:0] a, logic [11:0] b, logic [11:0] c);
    svn_pkg::in_item_t r;
    r.operation = op;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.corner_a = a;
    r.corner_b = b;
    r.corner_c = c;
    return r;
  endfunction

  // request with random don't-care fields
  function automatic svn_pkg::in_item_t noisy(svn_pkg::op_t op, logic [11:0] a,
                                              logic [11:0] b, logic [11:0] c);
    return req(op, 24'($urandom), 24'($urandom), 24'($urandom), a, b, c);
  endfunction

  // random 12-bit corner
  function automatic logic [11:0] any_corner();
    return 12'($urandom);
  endfunction

  // mix of zero, extreme, tiny and full-range coordinates
  function automatic logic [23:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return POS_MAX;
      2: return POS_MIN;
      3: return 24'($signed($urandom_range(0, 64)) - 32);
      default: return 24'($urandom);
    endcase
  endfunction

  // offer one request and wait for it to be taken; then maybe close the burst
  task automatic offer_request(svn_pkg::in_item_t r);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // gap between bursts, then pick the next burst length
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // one random mesh: loads, triangles, finish, reads, with some noise and bad requests
  task automatic random_mesh();
    int nv, nt, nr;
    logic [11:0] a, b, c;
    nv = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 24) : $urandom_range(3, 10);
    if ($urandom_range(0, 9) == 0)
      offer_request(noisy(svn_pkg::op_t'(2'($urandom_range(0, 3))),
                          any_corner(), any_corner(), any_corner()));
    for (int i = 0; i < nv; i++)
      offer_request(req(svn_pkg::OP_LOAD, pick_pos(), pick_pos(), pick_pos(), any_corner(),
                        any_corner(), any_corner()));
    nt = $urandom_range(0, 12);
    for (int i = 0; i < nt; i++) begin
      a = 12'($urandom_range(0, nv - 1));
      b = 12'($urandom_range(0, nv - 1));
      c = 12'($urandom_range(0, nv - 1));
      // an occasional corner past the loaded range poisons the mesh
      if ($urandom_range(0, 39) == 0) c = 12'($urandom_range(0, 4095));
      offer_request(noisy(svn_pkg::OP_TRI, a, b, c));
    end
    if ($urandom_range(0, 9) != 0)
      offer_request(noisy(svn_pkg::OP_FINISH, any_corner(), any_corner(), any_corner()));
    nr = $urandom_range(2, nv + 2);
    for (int i = 0; i < nr; i++) begin
      a = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, nv));
      offer_request(noisy(svn_pkg::OP_READ, a, any_corner(), any_corner()));
    end
    // noise after finish: triangles and repeat finishes
    if ($urandom_range(0, 4) == 0) offer_request(noisy(svn_pkg::OP_TRI, 0, 1, 2));
    if ($urandom_range(0, 4) == 0)
      offer_request(noisy(svn_pkg::OP_FINISH, any_corner(), any_corner(), any_corner()));
  endtask

  // receiver: stall pattern in stretches, plus one long hold-off on request
  initial begin
    int hold_left, mode, mode_left;
    bit hold_done;
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      out_stall <= (hold_left > 0) || (mode == 1 && $urandom_range(0, 7) == 0) ||
                   (mode == 2 && $urandom_range(0, 1) == 1);
    end
  end

  // result checking and the idle watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    hold_req = 0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // requests with no mesh yet
    offer_request(noisy(svn_pkg::OP_READ, 0, 0, 0));
    offer_request(noisy(svn_pkg::OP_TRI, 0, 1, 2));
    offer_request(noisy(svn_pkg::OP_FINISH, 0, 0, 0));
    // extreme and zero positions
    offer_request(req(svn_pkg::OP_LOAD, POS_MAX, POS_MAX, POS_MAX, 12'hfff, 12'hfff, 12'hfff));
    offer_request(req(svn_pkg::OP_LOAD, POS_MIN, POS_MIN, POS_MIN, 0, 0, 0));
    offer_request(req(svn_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0));
    offer_request(req(svn_pkg::OP_LOAD, POS_MAX, 0, POS_MIN, 0, 0, 0));
    offer_request(noisy(svn_pkg::OP_READ, 0, 0, 0));      // read while loading
    offer_request(noisy(svn_pkg::OP_TRI, 0, 1, 3));
    offer_request(noisy(svn_pkg::OP_TRI, 0, 0, 1));       // repeated corner, zero area
    offer_request(noisy(svn_pkg::OP_TRI, 0, 1, 2));       // collinear, zero area
    offer_request(noisy(svn_pkg::OP_READ, 0, 0, 0));      // read before finish
    offer_request(noisy(svn_pkg::OP_FINISH, 0, 0, 0));
    for (int i = 0; i < 4; i++) offer_request(noisy(svn_pkg::OP_READ, 12'(i), 0, 0));
    offer_request(noisy(svn_pkg::OP_READ, 4, 0, 0));      // just past the mesh
    offer_request(noisy(svn_pkg::OP_READ, 12'hfff, 0, 0));
    offer_request(noisy(svn_pkg::OP_FINISH, 0, 0, 0));    // finish again
    offer_request(noisy(svn_pkg::OP_READ, 3, 0, 0));
    offer_request(noisy(svn_pkg::OP_TRI, 0, 1, 3));       // triangle after finish
    // new mesh with a bad corner, finish refused
    offer_request(req(svn_pkg::OP_LOAD, 24'sd100, 0, 0, 0, 0, 0));
    offer_request(req(svn_pkg::OP_LOAD, 0, 24'sd100, 0, 0, 0, 0));
    offer_request(noisy(svn_pkg::OP_TRI, 0, 1, 12'hfff));
    offer_request(noisy(svn_pkg::OP_FINISH, 0, 0, 0));
    offer_request(noisy(svn_pkg::OP_READ, 0, 0, 0));

    // random meshes; the long receiver hold starts with them
    hold_req = 1;
    while (items_sent < TOTAL_ITEMS) random_mesh();

    @(posedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ smooth_vertex_normals.f @@
rtl/svn_pkg.sv
rtl/svn_norm.sv
rtl/smooth_vertex_normals.sv
tb/smooth_vertex_normals_tb.sv
